// File: src/mqrr_pkg.sv
// mqrr_pkg: shared types, constants and helpers for the multi-queue record ring
// used by mqrr_ctrl, mqrr_dpath and multi_queue_record_ring_core
package mqrr_pkg;

	localparam int MAX_QUEUES   = 128;
	localparam int DEPTH        = 1024;
	localparam int QID_W        = $clog2(MAX_QUEUES);
	localparam int PTR_W        = $clog2(DEPTH);
	localparam int REC_AW       = QID_W + PTR_W;
	localparam int REC_DEPTH    = MAX_QUEUES * DEPTH;
	localparam int CFG_W        = 8;
	localparam int PID_W        = 32;
	localparam int ADDR_W       = 64;
	localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(1);
	localparam logic [CFG_W-1:0] ACTIVE_MAX   = CFG_W'(MAX_QUEUES);

	typedef logic [PTR_W-1:0] ptr_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		op_t               op;
		logic [6:0]        queue_id;
		logic [PID_W-1:0]  pid;
		logic [ADDR_W-1:0] first_addr;
		logic [ADDR_W-1:0] last_addr;
	} in_t;

	typedef struct packed {
		status_t           status;
		logic [PID_W-1:0]  rd_pid;
		logic [ADDR_W-1:0] rd_start;
		logic [ADDR_W-1:0] rd_end;
	} out_t;

	typedef struct packed {
		logic [PID_W-1:0]  pid;
		logic [ADDR_W-1:0] first_addr;
		logic [ADDR_W-1:0] last_addr;
	} rec_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PTR,
		S_EXEC,
		S_PUSH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic ptr_rd;
		logic exec;
		logic push;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} sts_t;

	function automatic ptr_t ptr_advance(input ptr_t p);
		ptr_t res;
		if (p == PTR_W'(DEPTH - 1)) begin
			res = '0;
		end else begin
			res = p + PTR_W'(1);
		end
		return res;
	endfunction

endpackage

// File: src/mqrr_ctrl.sv
// mqrr_ctrl: request sequencer for the multi-queue record ring
// depends on mqrr_pkg
module mqrr_ctrl import mqrr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd         = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = S_PTR;
				end
			end
			S_PTR: begin
				cmd.ptr_rd = 1'b1;
				state_d    = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_PUSH;
			end
			S_PUSH: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: src/mqrr_dpath.sv
// mqrr_dpath: pointer tables, record memory, range check and result register
// depends on mqrr_pkg; driven by mqrr_ctrl commands
module mqrr_dpath import mqrr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  in_t              in_data,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             out_ready,
	output logic             out_valid,
	output out_t             out_data
);

	logic [CFG_W-1:0]      active_q;
	in_t                   req_q;
	logic                  range_ok_q;
	logic [CFG_W-1:0]      limit;
	logic                  range_ok;

	ptr_t                  wp_mem [MAX_QUEUES];
	ptr_t                  rp_mem [MAX_QUEUES];
	logic [MAX_QUEUES-1:0] wp_vld_q;
	logic [MAX_QUEUES-1:0] rp_vld_q;
	ptr_t                  wp_rd_q;
	ptr_t                  rp_rd_q;
	logic                  wp_rv_q;
	logic                  rp_rv_q;
	ptr_t                  wp_cur;
	ptr_t                  rp_cur;
	logic                  empty;
	logic                  do_wr;
	logic                  do_rd;
	logic [REC_AW-1:0]     rec_addr;
	rec_t                  rec_wdata;

	rec_t                  rec_mem [REC_DEPTH];
	rec_t                  rec_rd_q;
	status_t               status_q;
	status_t               status_d;
	logic                  rd_ok_q;
	logic                  out_valid_q;
	out_t                  out_q;

	// active count clamped to the number of queues built
	assign limit    = (active_q > ACTIVE_MAX) ? ACTIVE_MAX : active_q;
	assign range_ok = (CFG_W'(in_data.queue_id) < limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (cfg_we) begin
			active_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q      <= in_data;
			range_ok_q <= range_ok;
		end
	end

	// pointer tables: an entry with a clear valid bit reads as zero
	assign wp_cur = wp_rv_q ? wp_rd_q : '0;
	assign rp_cur = rp_rv_q ? rp_rd_q : '0;
	assign empty  = (wp_cur == rp_cur);
	assign do_wr  = cmd.exec && range_ok_q && (req_q.op == OP_WRITE);
	assign do_rd  = cmd.exec && range_ok_q && (req_q.op == OP_READ) && !empty;

	always_ff @(posedge clk) begin
		if (cmd.ptr_rd) begin
			wp_rd_q <= wp_mem[req_q.queue_id];
			rp_rd_q <= rp_mem[req_q.queue_id];
		end
		if (do_wr) begin
			wp_mem[req_q.queue_id] <= ptr_advance(wp_cur);
		end
		if (do_rd) begin
			rp_mem[req_q.queue_id] <= ptr_advance(rp_cur);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_vld_q <= '0;
			rp_vld_q <= '0;
			wp_rv_q  <= 1'b0;
			rp_rv_q  <= 1'b0;
		end else begin
			if (cmd.ptr_rd) begin
				wp_rv_q <= wp_vld_q[req_q.queue_id];
				rp_rv_q <= rp_vld_q[req_q.queue_id];
			end
			if (do_wr) begin
				wp_vld_q[req_q.queue_id] <= 1'b1;
			end
			if (do_rd) begin
				rp_vld_q[req_q.queue_id] <= 1'b1;
			end
		end
	end

	// record memory, slot = queue * DEPTH + pointer
	assign rec_addr = {req_q.queue_id, (req_q.op == OP_WRITE) ? wp_cur : rp_cur};
	assign rec_wdata = '{pid: req_q.pid, first_addr: req_q.first_addr,
		last_addr: req_q.last_addr};

	always_ff @(posedge clk) begin
		if (do_wr) begin
			rec_mem[rec_addr] <= rec_wdata;
		end
		if (do_rd) begin
			rec_rd_q <= rec_mem[rec_addr];
		end
	end

	always_comb begin
		if (!range_ok_q) begin
			status_d = ST_RANGE;
		end else if ((req_q.op == OP_READ) && empty) begin
			status_d = ST_EMPTY;
		end else begin
			status_d = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= status_d;
			rd_ok_q  <= do_rd;
		end
		if (cmd.push) begin
			out_q.status   <= status_q;
			out_q.rd_pid   <= rd_ok_q ? rec_rd_q.pid : '0;
			out_q.rd_start <= rd_ok_q ? rec_rd_q.first_addr : '0;
			out_q.rd_end   <= rd_ok_q ? rec_rd_q.last_addr : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

`ifndef NO_ASSERTIONS
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> sts.out_free)
		else $error("result pushed over an untaken result");
	a_push_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> out_valid_q)
		else $error("pushed result not presented");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.status != ST_OK)) |->
		(out_q.rd_pid == '0 && out_q.rd_start == '0 && out_q.rd_end == '0))
		else $error("failed request carries record data");
	a_wr_mark: assert property (@(posedge clk) disable iff (!arst_n)
		do_wr |=> wp_vld_q[$past(req_q.queue_id)])
		else $error("written queue pointer not marked valid");
`endif

endmodule

// File: src/multi_queue_record_ring_core.sv
// multi_queue_record_ring_core: top level of the multi-queue record ring
// depends on mqrr_pkg, mqrr_ctrl and mqrr_dpath
// sequence: request accept, pointer read, memory access, result load; one request in flight,
//   so a new request is taken only after the result of the last one is loaded
// the pointer tables and the record memory each have one read port
// reset: async active low; all pointers read as zero, active_queues = 1, record memory untouched
module multi_queue_record_ring_core import mqrr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// request channel
	input  logic             in_valid,
	output logic             in_ready,
	input  in_t              in_data,
	// result channel
	output logic             out_valid,
	input  logic             out_ready,
	output out_t             out_data,
	// active_queues register write
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	// sequencer: idle -> pointer read -> memory access -> result load
	mqrr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// pointer tables, record store and result register
	mqrr_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_we    (cfg_valid),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

// File: bench/tb_multi_queue_record_ring_core.sv
// tb_multi_queue_record_ring_core: self-checking bench for the multi-queue record ring
// needs mqrr_pkg and multi_queue_record_ring_core; keeps its own ring model to predict responses
module tb_multi_queue_record_ring_core;
	timeunit 1ns;
	timeprecision 1ps;
	import mqrr_pkg::*;

	// clock, reset and the three channels
	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	in_t              in_data   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_t             out_data;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data  = '0;

	// ring model: record memory is sparse, only written slots exist
	rec_t             ring_mem [int];
	ptr_t             wr_ptr [MAX_QUEUES];
	ptr_t             rd_ptr [MAX_QUEUES];
	logic [CFG_W-1:0] active_q;

	// responses predicted at request accept, oldest first
	out_t pending_responses [$];

	// idle odds in percent for the request side and the response side
	int snd_idle_pct;
	int rcv_idle_pct;

	int n_errors   = 0;
	int n_requests = 0;
	int n_ok       = 0;
	int n_empty    = 0;
	int n_range    = 0;

	multi_queue_record_ring_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		n_errors++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	// queues at or above this number are rejected; counts above MAX_QUEUES saturate
	function automatic int queue_limit();
		return (int'(active_q) > MAX_QUEUES) ? MAX_QUEUES : int'(active_q);
	endfunction

	function automatic ptr_t next_slot(input ptr_t p);
		return ptr_t'((int'(p) + 1) % DEPTH);
	endfunction

	// applies one request to the ring model and returns the response it owes
	function automatic out_t ring_response(input in_t req);
		out_t resp;
		int   q;
		int   slot;
		resp = '0;
		q    = int'(req.queue_id);
		if (q >= queue_limit()) begin
			// inactive queue: nothing moves
			resp.status = ST_RANGE;
		end else if (req.op == OP_WRITE) begin
			// no full check, a lap that was never read gets overwritten
			slot           = q * DEPTH + int'(wr_ptr[q]);
			ring_mem[slot] = {req.pid, req.first_addr, req.last_addr};
			wr_ptr[q]      = next_slot(wr_ptr[q]);
		end else if (rd_ptr[q] == wr_ptr[q]) begin
			resp.status = ST_EMPTY;
		end else begin
			slot          = q * DEPTH + int'(rd_ptr[q]);
			resp.rd_pid   = ring_mem[slot].pid;
			resp.rd_start = ring_mem[slot].first_addr;
			resp.rd_end   = ring_mem[slot].last_addr;
			rd_ptr[q]     = next_slot(rd_ptr[q]);
		end
		return resp;
	endfunction

	function automatic in_t rec_request(input op_t op, input int qid, input logic [PID_W-1:0] pid,
			input logic [ADDR_W-1:0] sa, input logic [ADDR_W-1:0] ea);
		in_t req;
		req.op         = op;
		req.queue_id   = qid[6:0];
		req.pid        = pid;
		req.first_addr = sa;
		req.last_addr  = ea;
		return req;
	endfunction

	// random record content, also on reads where the block ignores it
	function automatic in_t random_request(input op_t op, input int qid);
		return rec_request(op, qid, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
	endfunction

	// one request through the handshake; entered and left at a rising edge
	task automatic send_request(input in_t req);
		if ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		// accepted at this edge, so the model moves now
		pending_responses.push_back(ring_response(req));
		n_requests++;
	endtask

	// hold requests back until every owed response has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_responses.size() != 0);
	endtask

	// active_queues write, only while the block is idle
	task automatic write_active(input logic [CFG_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		active_q = v;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// reset state: count of one, empty queue 0, extreme record values
	task automatic test_reset_state();
		send_request(random_request(OP_READ, 0));
		send_request(random_request(OP_WRITE, 1));
		send_request(random_request(OP_READ, 127));
		send_request(rec_request(OP_WRITE, 0, '1, '1, '1));
		send_request(rec_request(OP_WRITE, 0, '0, '0, '0));
		send_request(random_request(OP_READ, 0));
		send_request(random_request(OP_READ, 0));
		send_request(random_request(OP_READ, 0));
	endtask

	// zero count rejects all, a count above MAX_QUEUES saturates, full count
	task automatic test_active_count();
		wait_drained();
		write_active('0);
		send_request(random_request(OP_WRITE, 0));
		send_request(random_request(OP_READ, 0));

		wait_drained();
		write_active('1);
		send_request(random_request(OP_WRITE, 127));
		send_request(random_request(OP_READ, 127));
		send_request(random_request(OP_READ, 127));
		send_request(rec_request(OP_WRITE, 64, {8{4'hA}}, {16{4'hA}}, {16{4'h5}}));
		send_request(random_request(OP_READ, 64));

		wait_drained();
		write_active(ACTIVE_MAX);
		send_request(rec_request(OP_WRITE, 127, {8{4'h5}}, {16{4'h5}}, {16{4'hA}}));
		send_request(random_request(OP_READ, 127));
		send_request(random_request(OP_READ, 0));
	endtask

	// a full lap of writes with no read: the queue reads empty, the lap is lost
	task automatic test_overrun();
		int q;
		wait_drained();
		write_active(CFG_W'($urandom_range(1, MAX_QUEUES)));
		q = $urandom_range(queue_limit() - 1);
		while (rd_ptr[q] != wr_ptr[q]) send_request(random_request(OP_READ, q));
		repeat (DEPTH) send_request(random_request(OP_WRITE, q));
		send_request(random_request(OP_READ, q));
		repeat (3) send_request(random_request(OP_WRITE, q));
		repeat (4) send_request(random_request(OP_READ, q));
	endtask

	// mixed traffic aimed mostly at a few hot queues so reads find records
	task automatic test_random_traffic(input int n_items);
		int lim;
		int q;
		for (int i = 0; i < n_items; i++) begin
			lim = queue_limit();
			if (lim == 0 || $urandom_range(9) == 0) begin
				q = $urandom_range(127);
			end else if ($urandom_range(3) == 0) begin
				q = $urandom_range(lim - 1);
			end else begin
				q = $urandom_range(((lim < 4) ? lim : 4) - 1);
			end
			send_request(random_request(($urandom_range(99) < 55) ? OP_WRITE : OP_READ, q));
		end
	endtask

	// response side stalls at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	// every accepted response against the oldest prediction
	always @(posedge clk) begin : check_resp
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_responses.size() == 0) begin
				report_mismatch("response with no request outstanding");
			end else begin
				want = pending_responses.pop_front();
				if (out_data.status !== want.status) begin
					report_mismatch($sformatf("status %0d, want %0d", out_data.status,
						want.status));
				end
				if (out_data.rd_pid !== want.rd_pid) begin
					report_mismatch($sformatf("rd_pid %h, want %h", out_data.rd_pid,
						want.rd_pid));
				end
				if (out_data.rd_start !== want.rd_start) begin
					report_mismatch($sformatf("rd_start %h, want %h", out_data.rd_start,
						want.rd_start));
				end
				if (out_data.rd_end !== want.rd_end) begin
					report_mismatch($sformatf("rd_end %h, want %h", out_data.rd_end,
						want.rd_end));
				end
				case (want.status)
					ST_OK:    n_ok++;
					ST_EMPTY: n_empty++;
					default:  n_range++;
				endcase
			end
		end
	end

	initial begin
		int guard;
		// model reset mirrors the block: pointers zero, count of one
		foreach (wr_ptr[i]) begin
			wr_ptr[i] = '0;
			rd_ptr[i] = '0;
		end
		active_q     = ACTIVE_RESET;
		snd_idle_pct = 12;
		rcv_idle_pct = 56;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first mix: sender mostly busy, receiver stalls often
		test_reset_state();
		test_active_count();
		test_overrun();

		// second mix: sender idles often, receiver mostly ready
		wait_drained();
		snd_idle_pct = 56;
		rcv_idle_pct = 12;
		write_active(CFG_W'($urandom_range(1, MAX_QUEUES)));
		test_random_traffic(100);
		// full stop until every response is back, then a new count
		wait_drained();
		write_active(CFG_W'($urandom_range(1, 255)));
		test_random_traffic(100);

		// back to back on both sides
		wait_drained();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		write_active('1);
		test_random_traffic(200);

		// drain, then keep watching for any stray response
		in_valid <= 1'b0;
		guard = 0;
		while (pending_responses.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (pending_responses.size() != 0) begin
			report_mismatch($sformatf("%0d responses never arrived", pending_responses.size()));
		end

		$display("ran %0d requests: %0d ok, %0d empty reads, %0d rejected queue numbers",
			n_requests, n_ok, n_empty, n_range);
		$display("active counts 0, 255, 128 and random, one full-lap overrun, three stall mixes");
		if (n_errors == 0) begin
			$display("[multi_queue_record_ring_core] OK");
		end else begin
			$display("[multi_queue_record_ring_core] ERROR");
		end
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#5ms;
		$display("timeout with %0d responses outstanding", pending_responses.size());
		$display("[multi_queue_record_ring_core] ERROR");
		$finish;
	end

endmodule
